>>> src/ventilator_breath_cycle_sequencer_macros.svh
// ----------------------------------------------------------------------------
// ventilator breath cycle sequencer assertion macros
// shared same-cycle and next-cycle implication property wrappers
// ----------------------------------------------------------------------------
`ifndef VENTILATOR_BREATH_CYCLE_SEQUENCER_MACROS_SVH
`define VENTILATOR_BREATH_CYCLE_SEQUENCER_MACROS_SVH

// same-cycle implication, checked outside reset
`define VBCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define VBCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/vbcs_pkg.sv
// ----------------------------------------------------------------------------
// vbcs_pkg
// types, codes and constants of the breath cycle sequencer
// ----------------------------------------------------------------------------
package vbcs_pkg;

  typedef enum logic [2:0] {
    PH_WAIT    = 3'd0,
    PH_IN_PRE  = 3'd1,
    PH_IN_PROC = 3'd2,
    PH_IN_POST = 3'd3,
    PH_EX_PRE  = 3'd4,
    PH_EX_PROC = 3'd5,
    PH_EX_POST = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    EXH_NONE  = 2'd0,
    EXH_OPEN  = 2'd1,
    EXH_PEEP  = 2'd2,
    EXH_CLOSE = 2'd3
  } exh_t;

  typedef enum logic [1:0] {
    INFO_NONE      = 2'd0,
    INFO_PEAK_MISS = 2'd1,
    INFO_BELOW_PEEP = 2'd2,
    INFO_PATIENT_TRIG = 2'd3
  } info_t;

  typedef enum logic [2:0] {
    REG_TIDAL_VOLUME = 3'd0,
    REG_INSP_PERCENT = 3'd1,
    REG_BREATHS_PER_MIN = 3'd2,
    REG_TRIGGER_PRESSURE = 3'd3,
    REG_PEEP_PRESSURE = 3'd4,
    REG_PEAK_PRESSURE = 3'd5,
    REG_OVERPRESSURE = 3'd6,
    REG_FLOW_MODE = 3'd7
  } reg_idx_t;

  localparam int unsigned ADDR_W = 5;

  // register reset values
  localparam logic [15:0]        RST_TIDAL_VOLUME = 16'd500;
  localparam logic [6:0]         RST_INSP_PERCENT = 7'd33;
  localparam logic [5:0]         RST_BREATHS_PER_MIN = 6'd15;
  localparam logic signed [15:0] RST_TRIGGER_PRESSURE = -16'sd20;
  localparam logic signed [15:0] RST_PEEP_PRESSURE = 16'sd50;
  localparam logic signed [15:0] RST_PEAK_PRESSURE = 16'sd200;
  localparam logic signed [15:0] RST_OVERPRESSURE = 16'sd400;

  // durations that follow from the reset registers
  localparam logic [5:0]  RST_CYCLE_S = 6'd4;
  localparam logic [12:0] RST_CYCLE_PCT = 13'd132;
  localparam logic [15:0] RST_CYCLE_MS = 16'd4000;
  localparam logic [15:0] RST_INSP_MS = 16'd1000;
  localparam logic [15:0] RST_EXP_MS = 16'd3000;

  localparam logic [6:0]  PCT_MAX = 7'd100;
  localparam logic [15:0] MS_PER_S = 16'd1000;
  // x / 100 == (x * 5243) >> 19 for every x up to 60 * 100
  localparam logic [25:0] RECIP_100 = 26'd5243;
  localparam int unsigned RECIP_SHIFT = 19;

  typedef struct packed {
    logic [15:0]        tidal_volume_ml;
    logic signed [15:0] trigger_pressure;
    logic signed [15:0] peep_pressure;
    logic signed [15:0] peak_pressure;
    logic signed [15:0] overpressure_limit;
    logic               flow_mode;
    logic [15:0]        cycle_ms;
    logic [15:0]        insp_ms;
    logic [15:0]        exp_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic signed [15:0] insp_pressure;
    logic signed [15:0] exp_pressure;
    logic [15:0]        delivered_volume_ml;
    logic               exit_valve_open;
  } tick_t;

  typedef struct packed {
    phase_t phase;
    exh_t   exh_valve_cmd;
    logic   insp_valve_close;
    logic   target_set;
    logic   flow_reset;
    logic   critical_alarm;
    info_t  info_alarm;
  } result_t;

  // whole seconds per breath, 60 / bpm truncated, zero rate gives zero
  function automatic logic [5:0] cycle_seconds(input logic [5:0] bpm);
    logic [5:0] s;
    case (bpm) inside
      6'd1:           s = 6'd60;
      6'd2:           s = 6'd30;
      6'd3:           s = 6'd20;
      6'd4:           s = 6'd15;
      6'd5:           s = 6'd12;
      6'd6:           s = 6'd10;
      6'd7:           s = 6'd8;
      6'd8:           s = 6'd7;
      [6'd9:6'd10]:   s = 6'd6;
      [6'd11:6'd12]:  s = 6'd5;
      [6'd13:6'd15]:  s = 6'd4;
      [6'd16:6'd20]:  s = 6'd3;
      [6'd21:6'd30]:  s = 6'd2;
      [6'd31:6'd60]:  s = 6'd1;
      default:        s = 6'd0;
    endcase
    return s;
  endfunction

endpackage

>>> src/vbcs_cfg.sv
// ----------------------------------------------------------------------------
// vbcs_cfg
// register file on the apb port and breath duration derivation
// ----------------------------------------------------------------------------
module vbcs_cfg import vbcs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [15:0]        tidal_r;
  logic [6:0]         pct_r;
  logic [5:0]         bpm_r;
  logic signed [15:0] trig_r;
  logic signed [15:0] peep_r;
  logic signed [15:0] peak_r;
  logic signed [15:0] over_r;
  logic               flow_r;

  logic [5:0]  cyc_s_r;
  logic [12:0] cyc_pct_r;
  logic [5:0]  cyc_s_nxt;
  logic [12:0] cyc_pct_nxt;
  logic [6:0]  pct_clamp;
  logic [25:0] scaled;
  logic [5:0]  in_s;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tidal_r <= RST_TIDAL_VOLUME;
      pct_r   <= RST_INSP_PERCENT;
      bpm_r   <= RST_BREATHS_PER_MIN;
      trig_r  <= RST_TRIGGER_PRESSURE;
      peep_r  <= RST_PEEP_PRESSURE;
      peak_r  <= RST_PEAK_PRESSURE;
      over_r  <= RST_OVERPRESSURE;
      flow_r  <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_TIDAL_VOLUME:     tidal_r <= pwdata[15:0];
        REG_INSP_PERCENT:     pct_r   <= pwdata[6:0];
        REG_BREATHS_PER_MIN:  bpm_r   <= pwdata[5:0];
        REG_TRIGGER_PRESSURE: trig_r  <= pwdata[15:0];
        REG_PEEP_PRESSURE:    peep_r  <= pwdata[15:0];
        REG_PEAK_PRESSURE:    peak_r  <= pwdata[15:0];
        REG_OVERPRESSURE:     over_r  <= pwdata[15:0];
        REG_FLOW_MODE:        flow_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TIDAL_VOLUME:     prdata = {16'd0, tidal_r};
      REG_INSP_PERCENT:     prdata = {25'd0, pct_r};
      REG_BREATHS_PER_MIN:  prdata = {26'd0, bpm_r};
      REG_TRIGGER_PRESSURE: prdata = 32'(trig_r);
      REG_PEEP_PRESSURE:    prdata = 32'(peep_r);
      REG_PEAK_PRESSURE:    prdata = 32'(peak_r);
      REG_OVERPRESSURE:     prdata = 32'(over_r);
      REG_FLOW_MODE:        prdata = {31'd0, flow_r};
      default:              prdata = 32'd0;
    endcase
  end

  // cycle seconds and seconds * percent, registered behind the multiplier
  assign pct_clamp   = (pct_r > PCT_MAX) ? PCT_MAX : pct_r;
  assign cyc_s_nxt   = cycle_seconds(bpm_r);
  assign cyc_pct_nxt = 13'(cyc_s_nxt) * 13'(pct_clamp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cyc_s_r   <= RST_CYCLE_S;
      cyc_pct_r <= RST_CYCLE_PCT;
    end else begin
      cyc_s_r   <= cyc_s_nxt;
      cyc_pct_r <= cyc_pct_nxt;
    end
  end

  // divide by 100 through the reciprocal, then scale to ms
  assign scaled = 26'(cyc_pct_r) * RECIP_100;
  assign in_s   = 6'(scaled >> RECIP_SHIFT);

  always_comb begin
    cfg.tidal_volume_ml    = tidal_r;
    cfg.trigger_pressure   = trig_r;
    cfg.peep_pressure      = peep_r;
    cfg.peak_pressure      = peak_r;
    cfg.overpressure_limit = over_r;
    cfg.flow_mode          = flow_r;
    cfg.cycle_ms           = 16'(cyc_s_r) * MS_PER_S;
    cfg.insp_ms            = 16'(in_s) * MS_PER_S;
    cfg.exp_ms             = 16'(cyc_s_r - in_s) * MS_PER_S;
  end

endmodule

>>> src/vbcs_seq.sv
// ----------------------------------------------------------------------------
// vbcs_seq
// breath phase state machine, one tick per enabled cycle
// ----------------------------------------------------------------------------
module vbcs_seq import vbcs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  tick_t   tick,
  input  cfg_t    cfg,
  output result_t res
);

  phase_t      phase_r, phase_nxt;
  logic [31:0] start_r, start_nxt;
  logic [15:0] insp_ms_r, insp_ms_nxt;
  logic [15:0] exp_ms_r, exp_ms_nxt;

  logic [31:0]        elapsed;
  logic [31:0]        exp_elapsed;
  logic               trig;
  logic               over;
  logic signed [16:0] peep_m1;

  assign elapsed     = tick.now_ms - start_r;
  assign exp_elapsed = elapsed - 32'(insp_ms_r);
  assign trig        = tick.insp_pressure <= cfg.trigger_pressure;
  assign over        = tick.insp_pressure > cfg.overpressure_limit;
  assign peep_m1     = 17'(cfg.peep_pressure) - 17'sd1;

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    start_nxt   = start_r;
    insp_ms_nxt = insp_ms_r;
    exp_ms_nxt  = exp_ms_r;
    case (phase_r)
      PH_WAIT: begin
        insp_ms_nxt = cfg.insp_ms;
        exp_ms_nxt  = cfg.exp_ms;
        if (trig || elapsed > 32'(cfg.cycle_ms)) begin
          phase_nxt = PH_IN_PRE;
        end
      end
      PH_IN_PRE: begin
        start_nxt = tick.now_ms;
        phase_nxt = PH_IN_PROC;
      end
      PH_IN_PROC: begin
        if ((cfg.flow_mode && tick.delivered_volume_ml >= cfg.tidal_volume_ml) ||
            elapsed >= 32'(insp_ms_r)) begin
          phase_nxt = PH_IN_POST;
        end
      end
      PH_IN_POST: begin
        if (elapsed >= 32'(insp_ms_r)) begin
          phase_nxt = PH_EX_PRE;
        end
      end
      PH_EX_PRE: phase_nxt = PH_EX_PROC;
      PH_EX_PROC: begin
        // a patient trigger wins over the expiration timeout
        if (trig) begin
          phase_nxt = PH_IN_PRE;
        end else if (exp_elapsed >= 32'(exp_ms_r)) begin
          phase_nxt = PH_EX_POST;
        end
      end
      PH_EX_POST: phase_nxt = PH_WAIT;
      default:    phase_nxt = PH_WAIT;
    endcase
  end

  // outputs
  always_comb begin
    res.phase            = phase_nxt;
    res.exh_valve_cmd    = over ? EXH_OPEN : EXH_NONE;
    res.insp_valve_close = over;
    res.target_set       = 1'b0;
    res.flow_reset       = 1'b0;
    res.critical_alarm   = over;
    res.info_alarm       = INFO_NONE;
    case (phase_r)
      PH_IN_PRE: begin
        res.flow_reset    = 1'b1;
        res.exh_valve_cmd = EXH_CLOSE;
        res.target_set    = 1'b1;
      end
      PH_IN_PROC: begin
        if (!cfg.flow_mode) begin
          res.target_set = 1'b1;
        end
      end
      PH_IN_POST: begin
        if (tick.exp_pressure < cfg.peak_pressure) begin
          res.exh_valve_cmd = EXH_CLOSE;
          res.info_alarm    = INFO_PEAK_MISS;
        end
        if (elapsed >= 32'(insp_ms_r)) begin
          res.insp_valve_close = 1'b1;
        end
      end
      PH_EX_PRE: res.exh_valve_cmd = EXH_PEEP;
      PH_EX_PROC: begin
        if (trig) begin
          res.info_alarm = INFO_PATIENT_TRIG;
        end
      end
      PH_EX_POST: begin
        if (17'(tick.exp_pressure) < peep_m1 && !tick.exit_valve_open) begin
          res.exh_valve_cmd = EXH_CLOSE;
          res.info_alarm    = INFO_BELOW_PEEP;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_WAIT;
      start_r   <= 32'd0;
      insp_ms_r <= RST_INSP_MS;
      exp_ms_r  <= RST_EXP_MS;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      start_r   <= start_nxt;
      insp_ms_r <= insp_ms_nxt;
      exp_ms_r  <= exp_ms_nxt;
    end
  end

endmodule

>>> src/ventilator_breath_cycle_sequencer.sv
// ----------------------------------------------------------------------------
// ventilator_breath_cycle_sequencer
// seven-phase breath cycle sequencer with valve commands and alarms
// ----------------------------------------------------------------------------
// an accepted beat waits in the input register until the result register frees up
// throughput: one beat per cycle without out_stall, set by the input and result registers
// under out_stall the input register takes at most one more beat, then in_stall rises
// reset (rst_n low, synchronous) empties both stages, returns to the wait phase
// and loads the default register values
module ventilator_breath_cycle_sequencer import vbcs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_now_ms,
  input  logic signed [15:0] in_insp_pressure,
  input  logic signed [15:0] in_exp_pressure,
  input  logic [15:0]        in_delivered_volume_ml,
  input  logic               in_exit_valve_open,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_phase,
  output logic [1:0]         out_exh_valve_cmd,
  output logic               out_insp_valve_close,
  output logic               out_target_set,
  output logic               out_flow_reset,
  output logic               out_critical_alarm,
  output logic [1:0]         out_info_alarm
);

  cfg_t    cfg;
  tick_t   tick_r;
  result_t res;
  result_t res_r;
  logic    tick_valid_r, tick_valid_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    advance;
  logic    in_take;

  vbcs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // the result register frees up when empty or when its beat is taken
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = tick_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign tick_valid_nxt = in_take ? 1'b1 : (advance ? 1'b0 : tick_valid_r);
  assign out_valid_nxt  = advance ? tick_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      tick_valid_r <= tick_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      tick_r.now_ms              <= in_now_ms;
      tick_r.insp_pressure       <= in_insp_pressure;
      tick_r.exp_pressure        <= in_exp_pressure;
      tick_r.delivered_volume_ml <= in_delivered_volume_ml;
      tick_r.exit_valve_open     <= in_exit_valve_open;
    end
  end

  vbcs_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (tick_valid_r && advance),
    .tick    (tick_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (tick_valid_r && advance) begin
      res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_phase            = res_r.phase;
  assign out_exh_valve_cmd    = res_r.exh_valve_cmd;
  assign out_insp_valve_close = res_r.insp_valve_close;
  assign out_target_set       = res_r.target_set;
  assign out_flow_reset       = res_r.flow_reset;
  assign out_critical_alarm   = res_r.critical_alarm;
  assign out_info_alarm       = res_r.info_alarm;

endmodule

>>> src/vbcs_checker.sv
// ----------------------------------------------------------------------------
// vbcs_checker
// port-level checks of the breath cycle sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "ventilator_breath_cycle_sequencer_macros.svh"

module vbcs_checker import vbcs_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [2:0]        out_phase,
  input logic [1:0]        out_exh_valve_cmd,
  input logic              out_insp_valve_close,
  input logic              out_target_set,
  input logic              out_flow_reset,
  input logic              out_critical_alarm,
  input logic [1:0]        out_info_alarm
);

  // a result beat held under stall keeps its phase and valve command
  `VBCS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_phase) && $stable(out_exh_valve_cmd), "stalled result beat changed")

  // input side only backs up when a finished result is stuck
  `VBCS_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without a blocked result")

  // overpressure always closes the inspiratory valve
  `VBCS_ASSERT_NOW(a_crit_close, out_valid && out_critical_alarm, out_insp_valve_close, "critical alarm without inspiratory close")

  // flow reset only on entry into inspiration, together with the target strobe
  `VBCS_ASSERT_NOW(a_flow_reset, out_valid && out_flow_reset, out_phase == PH_IN_PROC && out_target_set, "flow reset outside inspiration start")

  // a patient trigger in expiration restarts inspiration
  `VBCS_ASSERT_NOW(a_trig_restart, out_valid && out_info_alarm == INFO_PATIENT_TRIG, out_phase == PH_IN_PRE, "patient trigger without inspiration restart")

endmodule

bind ventilator_breath_cycle_sequencer vbcs_checker u_vbcs_checker (.*);

>>> bench/tb_ventilator_breath_cycle_sequencer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ventilator_breath_cycle_sequencer
// drives sensor ticks through the breath cycle sequencer under several register
// settings and gap patterns, predicts result beats in the bench or takes them
// from a directed table, and checks the outputs field by field in order
// ----------------------------------------------------------------------------
module tb_ventilator_breath_cycle_sequencer;
  import vbcs_pkg::*;

  typedef enum int {GAP_NONE, GAP_SRC, GAP_SINK, GAP_BOTH} gap_mode_t;

  typedef struct {
    logic [15:0]        tidal;
    logic [6:0]         pct;
    logic [5:0]         bpm;
    logic signed [15:0] trig;
    logic signed [15:0] peep;
    logic signed [15:0] peak;
    logic signed [15:0] over;
    logic               flow;
    gap_mode_t          gaps;
  } breath_setup_t;

  typedef struct {
    tick_t   tk;
    bit      typed;
    result_t want;
  } dir_row_t;

  bit clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_stall;
  logic [31:0] in_now_ms;
  logic signed [15:0] in_insp_pressure, in_exp_pressure;
  logic [15:0] in_delivered_volume_ml;
  logic in_exit_valve_open;
  logic out_valid, out_stall;
  logic [2:0] out_phase;
  logic [1:0] out_exh_valve_cmd;
  logic out_insp_valve_close, out_target_set, out_flow_reset, out_critical_alarm;
  logic [1:0] out_info_alarm;

  ventilator_breath_cycle_sequencer u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // bench copy of the sequencer registers and state
  logic [15:0]        rg_tidal;
  logic [6:0]         rg_pct;
  logic [5:0]         rg_bpm;
  logic signed [15:0] rg_trig, rg_peep, rg_peak, rg_over;
  logic               rg_flow;
  phase_t             breath_phase;
  logic [31:0]        breath_start;
  logic [31:0]        cycle_len_ms, insp_len_ms, exp_len_ms;

  result_t       awaited_commands[$];
  int            fails;
  int            src_idle_pct, sink_stall_pct;
  logic [31:0]   clock_ms;
  breath_setup_t setups[8];
  dir_row_t      dir_table[25];

  function automatic void latch_durations();
    int unsigned secs, pct, in_s;
    secs = (rg_bpm != 0) ? 60 / rg_bpm : 0;
    pct = (rg_pct > 100) ? 100 : rg_pct;
    in_s = secs * pct / 100;
    cycle_len_ms = secs * 1000;
    insp_len_ms = in_s * 1000;
    exp_len_ms = (secs - in_s) * 1000;
  endfunction

  task automatic reset_model();
    rg_tidal = RST_TIDAL_VOLUME;
    rg_pct = RST_INSP_PERCENT;
    rg_bpm = RST_BREATHS_PER_MIN;
    rg_trig = RST_TRIGGER_PRESSURE;
    rg_peep = RST_PEEP_PRESSURE;
    rg_peak = RST_PEAK_PRESSURE;
    rg_over = RST_OVERPRESSURE;
    rg_flow = 1'b0;
    breath_phase = PH_WAIT;
    breath_start = '0;
    latch_durations();
  endtask

  // one tick of the breath cycle: returns the commands and moves the state on
  function automatic result_t advance_breath(input tick_t t);
    result_t r;
    logic [31:0] elapsed;
    int pin, pex;
    bit trig, done;
    r = '0;
    elapsed = t.now_ms - breath_start;
    pin = $signed(t.insp_pressure);
    pex = $signed(t.exp_pressure);
    trig = (pin <= int'(rg_trig));
    if (pin > int'(rg_over)) begin
      r.exh_valve_cmd = EXH_OPEN;
      r.insp_valve_close = 1'b1;
      r.critical_alarm = 1'b1;
    end
    case (breath_phase)
      PH_WAIT: begin
        latch_durations();
        if (trig || elapsed > cycle_len_ms) breath_phase = PH_IN_PRE;
      end
      PH_IN_PRE: begin
        breath_start = t.now_ms;
        r.flow_reset = 1'b1;
        r.exh_valve_cmd = EXH_CLOSE;
        r.target_set = 1'b1;
        breath_phase = PH_IN_PROC;
      end
      PH_IN_PROC: begin
        done = 1'b0;
        if (rg_flow) begin
          if (t.delivered_volume_ml >= rg_tidal) done = 1'b1;
        end else begin
          r.target_set = 1'b1;
        end
        if (elapsed >= insp_len_ms) done = 1'b1;
        if (done) breath_phase = PH_IN_POST;
      end
      PH_IN_POST: begin
        if (pex < int'(rg_peak)) begin
          r.exh_valve_cmd = EXH_CLOSE;
          r.info_alarm = INFO_PEAK_MISS;
        end
        if (elapsed >= insp_len_ms) begin
          r.insp_valve_close = 1'b1;
          breath_phase = PH_EX_PRE;
        end
      end
      PH_EX_PRE: begin
        r.exh_valve_cmd = EXH_PEEP;
        breath_phase = PH_EX_PROC;
      end
      PH_EX_PROC: begin
        if (elapsed - insp_len_ms >= exp_len_ms) breath_phase = PH_EX_POST;
        // patient effort wins over a timeout on the same tick
        if (trig) begin
          breath_phase = PH_IN_PRE;
          r.info_alarm = INFO_PATIENT_TRIG;
        end
      end
      PH_EX_POST: begin
        if (pex < int'(rg_peep) - 1 && !t.exit_valve_open) begin
          r.exh_valve_cmd = EXH_CLOSE;
          r.info_alarm = INFO_BELOW_PEEP;
        end
        breath_phase = PH_WAIT;
      end
      default: begin
        breath_phase = PH_WAIT;
      end
    endcase
    r.phase = breath_phase;
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] near(input int base, input int spread);
    return sat16(base + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic dir_row_t mk(input logic [31:0] now, input int pin, input int pex,
                                  input int vol, input bit ex_open, input bit typed,
                                  input phase_t ph, input exh_t exh, input bit ic,
                                  input bit ts, input bit fr, input bit ca, input info_t ia);
    dir_row_t d;
    d.tk.now_ms = now;
    d.tk.insp_pressure = pin[15:0];
    d.tk.exp_pressure = pex[15:0];
    d.tk.delivered_volume_ml = vol[15:0];
    d.tk.exit_valve_open = ex_open;
    d.typed = typed;
    d.want = '0;
    d.want.phase = ph;
    d.want.exh_valve_cmd = exh;
    d.want.insp_valve_close = ic;
    d.want.target_set = ts;
    d.want.flow_reset = fr;
    d.want.critical_alarm = ca;
    d.want.info_alarm = ia;
    return d;
  endfunction

  // time mostly creeps forward at a pace matched to the breath length
  function automatic tick_t random_tick();
    tick_t t;
    int unsigned span, sel;
    int vol;
    span = ((cycle_len_ms > 1000) ? cycle_len_ms : 1000) / 3;
    sel = $urandom_range(0, 99);
    if (sel < 3) clock_ms = $urandom();
    else clock_ms += $urandom_range(0, span);
    t.now_ms = clock_ms;
    sel = $urandom_range(0, 99);
    if (sel < 75) t.insp_pressure = sat16(int'(rg_trig) + 1 + int'($urandom_range(0, 60)));
    else if (sel < 85) t.insp_pressure = near(rg_trig, 2);
    else if (sel < 95) t.insp_pressure = near(rg_over, 2);
    else t.insp_pressure = 16'($urandom());
    sel = $urandom_range(0, 99);
    if (sel < 40) t.exp_pressure = near(rg_peak, 3);
    else if (sel < 80) t.exp_pressure = near(rg_peep, 3);
    else t.exp_pressure = 16'($urandom());
    if ($urandom_range(0, 99) < 40) begin
      vol = int'(rg_tidal) + int'($urandom_range(0, 4)) - 2;
      if (vol < 0) vol = 0;
      if (vol > 65535) vol = 65535;
      t.delivered_volume_ml = vol[15:0];
    end else begin
      t.delivered_volume_ml = 16'($urandom());
    end
    t.exit_valve_open = 1'($urandom_range(0, 1));
    return t;
  endfunction

  task automatic send_tick(input tick_t t, input bit typed, input result_t want);
    result_t pred;
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_now_ms <= t.now_ms;
    in_insp_pressure <= t.insp_pressure;
    in_exp_pressure <= t.exp_pressure;
    in_delivered_volume_ml <= t.delivered_volume_ml;
    in_exit_valve_open <= t.exit_valve_open;
    do @(posedge clk); while (in_stall);
    pred = advance_breath(t);
    awaited_commands.push_back(typed ? want : pred);
  endtask

  task automatic wait_until_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_commands.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t r, input logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (r)
      REG_TIDAL_VOLUME:     rg_tidal = v[15:0];
      REG_INSP_PERCENT:     rg_pct = v[6:0];
      REG_BREATHS_PER_MIN:  rg_bpm = v[5:0];
      REG_TRIGGER_PRESSURE: rg_trig = v[15:0];
      REG_PEEP_PRESSURE:    rg_peep = v[15:0];
      REG_PEAK_PRESSURE:    rg_peak = v[15:0];
      REG_OVERPRESSURE:     rg_over = v[15:0];
      REG_FLOW_MODE:        rg_flow = v[0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_setup(input breath_setup_t s);
    cfg_write(REG_TIDAL_VOLUME, 32'(s.tidal));
    cfg_write(REG_INSP_PERCENT, 32'(s.pct));
    cfg_write(REG_BREATHS_PER_MIN, 32'(s.bpm));
    cfg_write(REG_TRIGGER_PRESSURE, 32'(s.trig));
    cfg_write(REG_PEEP_PRESSURE, 32'(s.peep));
    cfg_write(REG_PEAK_PRESSURE, 32'(s.peak));
    cfg_write(REG_OVERPRESSURE, 32'(s.over));
    cfg_write(REG_FLOW_MODE, 32'(s.flow));
    src_idle_pct = (s.gaps == GAP_SRC) ? 87 : (s.gaps == GAP_BOTH) ? 35 : 0;
    sink_stall_pct = (s.gaps == GAP_SINK) ? 87 : (s.gaps == GAP_BOTH) ? 35 : 0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < sink_stall_pct);

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_commands.size() == 0) begin
        $error("result beat with no command pending");
        fails++;
      end else begin
        want = awaited_commands.pop_front();
        check_field("phase", want.phase, out_phase);
        check_field("exh_valve_cmd", want.exh_valve_cmd, out_exh_valve_cmd);
        check_field("insp_valve_close", want.insp_valve_close, out_insp_valve_close);
        check_field("target_set", want.target_set, out_target_set);
        check_field("flow_reset", want.flow_reset, out_flow_reset);
        check_field("critical_alarm", want.critical_alarm, out_critical_alarm);
        check_field("info_alarm", want.info_alarm, out_info_alarm);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("ventilator_breath_cycle_sequencer regression: fail");
    $finish;
  end

  initial begin
    int i, p;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_now_ms = '0;
    in_insp_pressure = '0;
    in_exp_pressure = '0;
    in_delivered_volume_ml = '0;
    in_exit_valve_open = 1'b0;
    out_stall = 1'b0;
    fails = 0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    clock_ms = 32'd20000;
    reset_model();

    // walk through a whole breath on reset settings, then the odd corners
    dir_table = '{
      mk(0, 0, 0, 0, 0, 1, PH_WAIT, EXH_NONE, 0, 0, 0, 0, INFO_NONE),
      mk(4000, 0, 0, 65535, 1, 1, PH_WAIT, EXH_NONE, 0, 0, 0, 0, INFO_NONE),
      mk(4001, 0, 0, 0, 0, 1, PH_IN_PRE, EXH_NONE, 0, 0, 0, 0, INFO_NONE),
      mk(5000, 32767, 0, 0, 0, 1, PH_IN_PROC, EXH_CLOSE, 1, 1, 1, 1, INFO_NONE),
      mk(5999, -32768, 0, 65535, 0, 1, PH_IN_PROC, EXH_NONE, 0, 1, 0, 0, INFO_NONE),
      mk(6000, 0, 0, 0, 0, 1, PH_IN_POST, EXH_NONE, 0, 1, 0, 0, INFO_NONE),
      mk(6000, 0, -32768, 0, 0, 1, PH_EX_PRE, EXH_CLOSE, 1, 0, 0, 0, INFO_PEAK_MISS),
      mk(6001, 0, 0, 0, 0, 1, PH_EX_PROC, EXH_PEEP, 0, 0, 0, 0, INFO_NONE),
      mk(8999, 0, 0, 0, 0, 1, PH_EX_PROC, EXH_NONE, 0, 0, 0, 0, INFO_NONE),
      mk(9000, 0, 0, 0, 0, 1, PH_EX_POST, EXH_NONE, 0, 0, 0, 0, INFO_NONE),
      mk(9001, 0, 48, 0, 0, 1, PH_WAIT, EXH_CLOSE, 0, 0, 0, 0, INFO_BELOW_PEEP),
      mk(9001, -20, 0, 0, 0, 1, PH_IN_PRE, EXH_NONE, 0, 0, 0, 0, INFO_NONE),
      mk(10000, 0, 0, 0, 0, 0, PH_WAIT, EXH_NONE, 0, 0, 0, 0, INFO_NONE),
      mk(11000, 0, 0, 0, 0, 0, PH_WAIT, EXH_NONE, 0, 0, 0, 0, INFO_NONE),
      mk(11000, 0, 200, 0, 0, 1, PH_EX_PRE, EXH_NONE, 1, 0, 0, 0, INFO_NONE),
      mk(11500, 0, 0, 0, 0, 0, PH_WAIT, EXH_NONE, 0, 0, 0, 0, INFO_NONE),
      mk(14000, -21, 0, 0, 0, 1, PH_IN_PRE, EXH_NONE, 0, 0, 0, 0, INFO_PATIENT_TRIG),
      mk(32'hffff_ffff, 0, 0, 0, 0, 1, PH_IN_PROC, EXH_CLOSE, 0, 1, 1, 0, INFO_NONE),
      mk(998, 401, 0, 0, 0, 1, PH_IN_PROC, EXH_OPEN, 1, 1, 0, 1, INFO_NONE),
      mk(999, 400, 0, 0, 0, 0, PH_WAIT, EXH_NONE, 0, 0, 0, 0, INFO_NONE),
      mk(999, 0, 32767, 0, 1, 0, PH_WAIT, EXH_NONE, 0, 0, 0, 0, INFO_NONE),
      mk(1500, 0, 0, 0, 0, 0, PH_WAIT, EXH_NONE, 0, 0, 0, 0, INFO_NONE),
      mk(3999, 0, 0, 0, 0, 1, PH_EX_POST, EXH_NONE, 0, 0, 0, 0, INFO_NONE),
      mk(4000, 0, -32768, 0, 1, 1, PH_WAIT, EXH_NONE, 0, 0, 0, 0, INFO_NONE),
      mk(4000, 0, 0, 0, 0, 1, PH_IN_PRE, EXH_NONE, 0, 0, 0, 0, INFO_NONE)
    };

    setups = '{
      '{16'd300, 7'd40, 6'd20, -30, 50, 200, 400, 1'b1, GAP_NONE},
      '{16'd65535, 7'd100, 6'd60, -32768, 32767, 32767, 32767, 1'b0, GAP_SRC},
      '{16'd0, 7'd0, 6'd1, 32767, -32768, -32768, -32768, 1'b1, GAP_SINK},
      '{16'd1000, 7'd127, 6'd0, -100, 0, 100, 300, 1'b1, GAP_BOTH},
      '{16'd200, 7'd50, 6'd63, -50, 30, 150, 250, 1'b0, GAP_NONE},
      '{16'd800, 7'd25, 6'd12, -20, 50, 200, 400, 1'b1, GAP_SRC},
      '{16'd450, 7'd33, 6'd7, -40, 60, 180, 350, 1'b0, GAP_SINK},
      '{16'd500, 7'd33, 6'd15, -20, 50, 200, 400, 1'b0, GAP_BOTH}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < 25; i++) send_tick(dir_table[i].tk, dir_table[i].typed, dir_table[i].want);

    for (p = 0; p < 8; p++) begin
      wait_until_idle();
      apply_setup(setups[p]);
      // run this setting across the 32-bit time wrap
      if (p == 4) clock_ms = 32'hffff_f000;
      for (i = 0; i < 68; i++) begin
        if (i == 34) wait_until_idle();
        send_tick(random_tick(), 1'b0, '0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_commands.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fails == 0) $display("ventilator_breath_cycle_sequencer regression: pass");
    else $display("ventilator_breath_cycle_sequencer regression: fail");
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/vbcs_pkg.sv
src/vbcs_cfg.sv
src/vbcs_seq.sv
src/ventilator_breath_cycle_sequencer.sv
src/vbcs_checker.sv
bench/tb_ventilator_breath_cycle_sequencer.sv
